// ===== hw/rtl/mqpw_pkg.sv =====
// Package for the message queue with priority wait lists.
// Holds sizes, request and status codes, and the structs that the modules share.
// No dependencies.
package mqpw_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int ITEM_BITS     = 32;
  localparam int WAIT_SLOTS    = 8;
  localparam int TASK_COUNT    = 16;
  localparam int PRIORITY_BITS = 8;

  localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int TASK_BITS = $clog2(TASK_COUNT);
  localparam int LEN_BITS  = $clog2(WAIT_SLOTS + 1);
  localparam int CAP_BITS  = 5;

  // Request types.
  localparam logic [1:0] REQ_SEND     = 2'd0;
  localparam logic [1:0] REQ_RECV     = 2'd1;
  localparam logic [1:0] REQ_TRY_SEND = 2'd2;
  localparam logic [1:0] REQ_TRY_RECV = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_TRY_FAILED = 2'd1;
  localparam logic [1:0] ST_WAITING    = 2'd2;
  localparam logic [1:0] ST_LIST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_WAIT
  } op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  task_id;
    logic [7:0]  task_priority;
    logic [31:0] item_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_out;
    logic        wake_valid;
    logic [3:0]  wake_task;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic       accept;
    logic       exec;
    op_e        op;
    logic [1:0] status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_send;
    logic is_try;
    logic has_room;
    logic has_item;
    logic list_full;
  } sts_t;

endpackage

// ===== hw/rtl/message_queue_priority_waiters_core.sv =====
// Top level of the message queue with priority-ordered sender and receiver
// wait lists. Depends on mqpw_pkg, mqpw_ctrl, mqpw_dp (and mqpw_wlist below it).
//
//   Channel    Handshake                  Payload
//   --------   ------------------------   ------------------------------
//   request    start, busy                req_i  (mqpw_pkg::req_t)
//   result     done_o (one-cycle strobe)  rsp_o  (mqpw_pkg::rsp_t)
//   config     cfg_valid_i, cfg_ready_o   cfg_data_i (queue capacity)
//
// Every request is accepted in S_IDLE, then passes through S_EVAL, in which the
// controller picks the operation and the ring, counters and wait lists update,
// and then S_RESP, in which done_o is high. The evaluate state ends in the ring
// memory's registered read port. Wait-list insertion is done in that evaluate
// state by the compare-and-shift cells.
// Reset (rst_ni low, asynchronous) empties the ring and both wait lists and sets
// the capacity to sixteen; no clearing pass is needed.
// The result is shown for exactly one cycle and the receiver cannot stall it.
module message_queue_priority_waiters_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mqpw_pkg::req_t                  req_i,
  output logic                            done_o,
  output mqpw_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mqpw_pkg::CAP_BITS-1:0]   cfg_data_i
);

  mqpw_pkg::cmd_t cmd;
  mqpw_pkg::sts_t sts;

  // The capacity register takes a write in any cycle; the user must make writes
  // only while no request is in flight, as the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  mqpw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  mqpw_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== hw/rtl/mqpw_wlist.sv =====
// Priority-ordered wait list built from a row of compare-and-shift cells.
// Depends on mqpw_pkg.
module mqpw_wlist (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  ins_i,
  input  logic                                  pop_i,
  input  logic [mqpw_pkg::TASK_BITS-1:0]        id_i,
  input  logic [mqpw_pkg::PRIORITY_BITS-1:0]    prio_i,
  output logic [mqpw_pkg::TASK_BITS-1:0]        head_id_o,
  output logic                                  full_o,
  output logic                                  empty_o
);

  logic [mqpw_pkg::TASK_BITS-1:0]     ids_q   [mqpw_pkg::WAIT_SLOTS];
  logic [mqpw_pkg::PRIORITY_BITS-1:0] prios_q [mqpw_pkg::WAIT_SLOTS];
  logic [mqpw_pkg::LEN_BITS-1:0]      len_q, len_d;
  logic [mqpw_pkg::WAIT_SLOTS-1:0]    le;

  // Each cell flags a valid entry that stays ahead of the newcomer. The list
  // is sorted, so the flags form a prefix.
  always_comb begin
    for (int k = 0; k < mqpw_pkg::WAIT_SLOTS; k++) begin
      le[k] = (mqpw_pkg::LEN_BITS'(k) < len_q) && (prios_q[k] <= prio_i);
    end
  end

  always_comb begin
    len_d = len_q;
    if (ins_i) begin
      len_d = len_q + mqpw_pkg::LEN_BITS'(1);
    end else if (pop_i) begin
      len_d = len_q - mqpw_pkg::LEN_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < mqpw_pkg::WAIT_SLOTS; k++) begin
      if (ins_i) begin
        if (k > 0 && !le[(k > 0) ? k - 1 : 0]) begin
          ids_q[k]   <= ids_q[(k > 0) ? k - 1 : 0];
          prios_q[k] <= prios_q[(k > 0) ? k - 1 : 0];
        end else if (!le[k]) begin
          ids_q[k]   <= id_i;
          prios_q[k] <= prio_i;
        end
      end else if (pop_i && k < mqpw_pkg::WAIT_SLOTS - 1) begin
        ids_q[k]   <= ids_q[(k < mqpw_pkg::WAIT_SLOTS - 1) ? k + 1 : k];
        prios_q[k] <= prios_q[(k < mqpw_pkg::WAIT_SLOTS - 1) ? k + 1 : k];
      end
    end
  end

  assign head_id_o = ids_q[0];
  assign full_o    = (len_q == mqpw_pkg::LEN_BITS'(mqpw_pkg::WAIT_SLOTS));
  assign empty_o   = (len_q == '0);

endmodule

// ===== hw/rtl/mqpw_dp.sv =====
// Datapath: request register, item ring memory, ring indices and fill count,
// capacity register, both wait lists and the result register.
// Depends on mqpw_pkg and mqpw_wlist.
module mqpw_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mqpw_pkg::CAP_BITS-1:0]   cfg_data_i,
  input  mqpw_pkg::req_t                  req_i,
  input  mqpw_pkg::cmd_t                  cmd_i,
  output mqpw_pkg::sts_t                  sts_o,
  output mqpw_pkg::rsp_t                  rsp_o
);

  mqpw_pkg::req_t req_q;

  logic [mqpw_pkg::ITEM_BITS-1:0] ring_q [mqpw_pkg::QUEUE_DEPTH];
  logic [mqpw_pkg::ITEM_BITS-1:0] rd_data_q;
  logic [mqpw_pkg::IDX_BITS-1:0]  rd_idx_q, wr_idx_q;
  logic [mqpw_pkg::CNT_BITS-1:0]  fill_q;
  logic [mqpw_pkg::CAP_BITS-1:0]  cap_q;
  logic [mqpw_pkg::CNT_BITS-1:0]  eff_cap;

  logic [1:0]                     status_q;
  logic                           item_sel_q;
  logic                           wake_q;
  logic [mqpw_pkg::TASK_BITS-1:0] wake_task_q;

  logic is_send, is_try;
  logic do_push, do_pop, do_wait;
  logic snd_ins, snd_pop, snd_full, snd_empty;
  logic rcv_ins, rcv_pop, rcv_full, rcv_empty;
  logic [mqpw_pkg::TASK_BITS-1:0] snd_head, rcv_head;

  function automatic logic [mqpw_pkg::IDX_BITS-1:0] next_idx(
    input logic [mqpw_pkg::IDX_BITS-1:0] idx,
    input logic [mqpw_pkg::CNT_BITS-1:0] cap
  );
    if (32'(idx) + 32'd1 >= 32'(cap)) begin
      return '0;
    end
    return idx + mqpw_pkg::IDX_BITS'(1);
  endfunction

  // A capacity of zero acts as one, and one above the ring size as the size.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = mqpw_pkg::CNT_BITS'(1);
    end else if (32'(cap_q) > mqpw_pkg::QUEUE_DEPTH) begin
      eff_cap = mqpw_pkg::CNT_BITS'(mqpw_pkg::QUEUE_DEPTH);
    end else begin
      eff_cap = mqpw_pkg::CNT_BITS'(cap_q);
    end
  end

  assign is_send = req_q.req_type inside {mqpw_pkg::REQ_SEND, mqpw_pkg::REQ_TRY_SEND};
  assign is_try  = req_q.req_type inside {mqpw_pkg::REQ_TRY_SEND, mqpw_pkg::REQ_TRY_RECV};

  assign sts_o.is_send   = is_send;
  assign sts_o.is_try    = is_try;
  assign sts_o.has_room  = (fill_q < eff_cap);
  assign sts_o.has_item  = (fill_q != '0);
  assign sts_o.list_full = is_send ? snd_full : rcv_full;

  assign do_push = cmd_i.exec && (cmd_i.op == mqpw_pkg::OP_PUSH);
  assign do_pop  = cmd_i.exec && (cmd_i.op == mqpw_pkg::OP_POP);
  assign do_wait = cmd_i.exec && (cmd_i.op == mqpw_pkg::OP_WAIT);

  assign rcv_pop = do_push && !rcv_empty;
  assign snd_pop = do_pop && !snd_empty;
  assign snd_ins = do_wait && is_send;
  assign rcv_ins = do_wait && !is_send;

  mqpw_wlist u_send_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (snd_ins),
    .pop_i     (snd_pop),
    .id_i      (req_q.task_id[mqpw_pkg::TASK_BITS-1:0]),
    .prio_i    (req_q.task_priority[mqpw_pkg::PRIORITY_BITS-1:0]),
    .head_id_o (snd_head),
    .full_o    (snd_full),
    .empty_o   (snd_empty)
  );

  mqpw_wlist u_recv_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (rcv_ins),
    .pop_i     (rcv_pop),
    .id_i      (req_q.task_id[mqpw_pkg::TASK_BITS-1:0]),
    .prio_i    (req_q.task_priority[mqpw_pkg::PRIORITY_BITS-1:0]),
    .head_id_o (rcv_head),
    .full_o    (rcv_full),
    .empty_o   (rcv_empty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      fill_q   <= '0;
      cap_q    <= mqpw_pkg::CAP_BITS'(16);
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (do_push) begin
        wr_idx_q <= next_idx(wr_idx_q, eff_cap);
        fill_q   <= fill_q + mqpw_pkg::CNT_BITS'(1);
      end else if (do_pop) begin
        rd_idx_q <= next_idx(rd_idx_q, eff_cap);
        fill_q   <= fill_q - mqpw_pkg::CNT_BITS'(1);
      end
    end
  end

  // Ring memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ring_q[wr_idx_q] <= req_q.item_data[mqpw_pkg::ITEM_BITS-1:0];
    end
    if (do_pop) begin
      rd_data_q <= ring_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      status_q    <= cmd_i.status;
      item_sel_q  <= do_pop;
      wake_q      <= rcv_pop || snd_pop;
      wake_task_q <= rcv_pop ? rcv_head : (snd_pop ? snd_head : '0);
    end
  end

  assign rsp_o.status     = status_q;
  assign rsp_o.item_out   = item_sel_q ? 32'(rd_data_q) : '0;
  assign rsp_o.wake_valid = wake_q;
  assign rsp_o.wake_task  = 4'(wake_task_q);

endmodule

// ===== hw/rtl/mqpw_ctrl.sv =====
// Controller state machine: takes a request, decides the operation from the
// datapath status and strobes the result. Depends on mqpw_pkg.
module mqpw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mqpw_pkg::sts_t  sts_i,
  output mqpw_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q, done_q;
  logic   ok;

  assign ok = sts_i.is_send ? sts_i.has_room : sts_i.has_item;

  always_comb begin
    cmd_o.accept = (state_q == S_IDLE) && start_i;
    cmd_o.exec   = (state_q == S_EVAL);
    if (ok) begin
      cmd_o.op     = sts_i.is_send ? mqpw_pkg::OP_PUSH : mqpw_pkg::OP_POP;
      cmd_o.status = mqpw_pkg::ST_DONE;
    end else if (sts_i.is_try) begin
      cmd_o.op     = mqpw_pkg::OP_NONE;
      cmd_o.status = mqpw_pkg::ST_TRY_FAILED;
    end else if (sts_i.list_full) begin
      cmd_o.op     = mqpw_pkg::OP_NONE;
      cmd_o.status = mqpw_pkg::ST_LIST_FULL;
    end else begin
      cmd_o.op     = mqpw_pkg::OP_WAIT;
      cmd_o.status = mqpw_pkg::ST_WAITING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= S_EVAL;
            busy_q  <= 1'b1;
          end
        end
        S_EVAL: begin
          state_q <= S_RESP;
          done_q  <= 1'b1;
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/mqpw_chk.sv =====
// Port-level checker for the message queue core, with its bind statement.
// Depends on mqpw_pkg and message_queue_priority_waiters_core.
module mqpw_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input mqpw_pkg::rsp_t rsp_o
);

  // An accepted request raises done_o once the controller has passed through S_EVAL.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing two cycles after accept");

  // One strobe per request.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // A result only appears while a request is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // Only a completed operation wakes a task or returns an item.
  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != mqpw_pkg::ST_DONE) |->
      (!rsp_o.wake_valid && rsp_o.item_out == '0))
    else $error("wake or item reported on a request that did not complete");

  // A task id without a wake is zero.
  a_wake_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.wake_valid) |-> (rsp_o.wake_task == '0))
    else $error("wake task set without wake");

endmodule

bind message_queue_priority_waiters_core mqpw_chk u_mqpw_chk (.*);
